@@ design/bounded_lifo_stack_macros.svh @@
// Assertion macros shared by the stack modules.
`ifndef BOUNDED_LIFO_STACK_MACROS_SVH
`define BOUNDED_LIFO_STACK_MACROS_SVH

// Check that cond holds on the same edge whenever trig holds.
`define BLSTK_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("stack assertion failed");

// Check that cond holds on the edge after trig holds.
`define BLSTK_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("stack assertion failed");

`endif

@@ design/blstk_pkg.sv @@
// Shared types, constants and helpers for the bounded LIFO stack.
package blstk_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int LIM_W      = 9;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    opcode_t                        opcode;
    logic signed [DATA_WIDTH-1:0]   push_value;
  } req_t;

  typedef struct packed {
    status_t                        status;
    logic signed [DATA_WIDTH-1:0]   read_value;
    logic [CNT_W-1:0]               item_count;
    logic                           is_empty;
    logic                           is_full;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // Clamp a written limit into 1..DEPTH.
  function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIM_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

@@ design/blstk_ctrl.sv @@
// Controller state machine: sequences request capture and execution.
`include "bounded_lifo_stack_macros.svh"

module blstk_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output blstk_pkg::ctrl_cmd_t  cmd
);

  blstk_pkg::ctrl_state_t state;
  blstk_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blstk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    cmd        = '0;
    case (state)
      blstk_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = blstk_pkg::ST_EXEC;
        end
      end
      blstk_pkg::ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = blstk_pkg::ST_IDLE;
      end
      default: begin
        state_next = blstk_pkg::ST_IDLE;
      end
    endcase
  end

  `BLSTK_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `BLSTK_ASSERT_NEXT(a_busy_one_cycle, clk, rst, busy, !busy)
  `BLSTK_ASSERT_NEXT(a_load_then_exec, clk, rst, cmd.load, cmd.exec && !cmd.load)

endmodule

@@ design/blstk_dp.sv @@
// Datapath: stack memory, entry count, limit register and result register.
`include "bounded_lifo_stack_macros.svh"

module blstk_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  blstk_pkg::ctrl_cmd_t                 cmd,
  input  blstk_pkg::req_t                      req,
  input  logic                                 cfg_we,
  input  logic [blstk_pkg::LIM_W-1:0]          cfg_data,
  output blstk_pkg::rsp_t                      rsp,
  output logic                                 done
);

  logic [blstk_pkg::DATA_WIDTH-1:0] mem [blstk_pkg::DEPTH];

  logic [blstk_pkg::CNT_W-1:0]      count;
  logic [blstk_pkg::CNT_W-1:0]      count_next;
  logic [blstk_pkg::CNT_W-1:0]      lim;
  logic [blstk_pkg::CNT_W-1:0]      count_m1;
  blstk_pkg::opcode_t               op_q;
  logic [blstk_pkg::DATA_WIDTH-1:0] val_q;
  logic [blstk_pkg::DATA_WIDTH-1:0] rd_q;

  blstk_pkg::status_t               stat;
  logic [blstk_pkg::DATA_WIDTH-1:0] rd_val;
  logic                             wr_en;

  assign count_m1 = count - blstk_pkg::CNT_W'(1);

  // Capture the request and prefetch the top entry; write a pushed value into the stack memory.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= req.opcode;
      val_q <= req.push_value;
      rd_q  <= mem[count_m1[blstk_pkg::ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[count[blstk_pkg::ADDR_W-1:0]] <= val_q;
    end
  end

  always_comb begin
    count_next = count;
    stat       = blstk_pkg::STAT_OK;
    rd_val     = '0;
    wr_en      = 1'b0;
    case (op_q)
      blstk_pkg::OP_PUSH: begin
        if (count >= lim) begin
          stat = blstk_pkg::STAT_FULL;
        end else begin
          wr_en      = cmd.exec;
          count_next = count + blstk_pkg::CNT_W'(1);
        end
      end
      blstk_pkg::OP_POP, blstk_pkg::OP_PEEK: begin
        if (count == '0) begin
          stat = blstk_pkg::STAT_EMPTY;
        end else begin
          rd_val = rd_q;
          if (op_q == blstk_pkg::OP_POP) begin
            count_next = count_m1;
          end
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lim   <= blstk_pkg::CNT_W'(blstk_pkg::DEPTH);
      done  <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        count <= count_next;
      end
      if (cfg_we) begin
        lim <= blstk_pkg::clamp_limit(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.status     <= stat;
      rsp.read_value <= rd_val;
      rsp.item_count <= count_next;
      rsp.is_empty   <= (count_next == '0);
      rsp.is_full    <= (count_next >= lim);
    end
  end

  `BLSTK_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= blstk_pkg::CNT_W'(blstk_pkg::DEPTH))
  `BLSTK_ASSERT_NOW(a_empty_flag, clk, rst, done, rsp.is_empty == (rsp.item_count == '0))
  `BLSTK_ASSERT_NOW(a_error_zero, clk, rst, done && rsp.status != blstk_pkg::STAT_OK, rsp.read_value == '0)

endmodule

@@ design/bounded_lifo_stack.sv @@
// Top level of the bounded LIFO stack: controller plus datapath.
// Flow: a request taken at a clock edge is captured into the request registers,
//   executed while busy is high, and its result beat, with done high, is registered.
// A new request is not taken while busy is high, which it is for the execute cycle.
// Results are never held off: each is shown for one cycle only.
// Reset: count cleared, limit set to 256; memory contents are not cleared.
module bounded_lifo_stack (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  blstk_pkg::req_t                      req,
  // result channel, one beat per request
  output logic                                 done,
  output blstk_pkg::rsp_t                      rsp,
  // limit register write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [blstk_pkg::LIM_W-1:0]          cfg_data
);

  blstk_pkg::ctrl_cmd_t cmd;

  // The user must write the limit only while idle; the block does not enforce it, so take every beat at once.
  assign cfg_ready = 1'b1;

  // Sequence capture and execution of each request.
  blstk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the stack, count and limit; register each result beat.
  blstk_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .rsp      (rsp),
    .done     (done)
  );

endmodule

@@ verif/bounded_lifo_stack_test.sv @@
// Self-checking testbench for the bounded LIFO stack: directed table, then random phases.
`timescale 1ns / 1ps

module bounded_lifo_stack_test;
  import blstk_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 8;
  localparam int NUM_PHASES   = 8;
  localparam int SHOWN_ERRORS = 10;

  // Kind of one row in the directed table.
  typedef enum logic [1:0] {
    ROW_RUN   = 2'd0,  // request checked against the predictor
    ROW_CHECK = 2'd1,  // request with its result typed in
    ROW_LIMIT = 2'd2   // write the limit register while idle
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    opcode_t           op;
    logic [31:0]       val;
    logic [LIM_W-1:0]  lim;
    rsp_t              want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  req_t             req;
  logic             done;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LIM_W-1:0] cfg_data;

  // Predictor state: its own copy of the stack, the count and the limit.
  logic [DATA_WIDTH-1:0] model_mem [DEPTH];
  int                    model_count;
  logic [LIM_W-1:0]      model_limit;

  rsp_t     pending_rsp [$];
  dir_row_t dir_tab [$];
  int       err_cnt;
  int       cycles;
  int       burst_left;

  bounded_lifo_stack dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result of one request and advance the predictor state.
  function automatic rsp_t predict_stack(opcode_t op, logic [31:0] val);
    rsp_t r;
    int   lim;
    lim = int'(model_limit);
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_PUSH: begin
        if (model_count >= lim) begin
          r.status = STAT_FULL;
        end else begin
          model_mem[model_count] = val;
          model_count++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.read_value = model_mem[model_count-1];
          if (op == OP_POP) model_count--;
        end
      end
      default: begin
        model_count = 0;
      end
    endcase
    r.item_count = CNT_W'(model_count);
    r.is_empty   = (model_count == 0);
    r.is_full    = (model_count >= lim);
    return r;
  endfunction

  function automatic rsp_t mk_rsp(status_t s, logic [31:0] v, logic [CNT_W-1:0] c,
                                  logic e, logic f);
    rsp_t r;
    r.status     = s;
    r.read_value = v;
    r.item_count = c;
    r.is_empty   = e;
    r.is_full    = f;
    return r;
  endfunction

  function automatic dir_row_t row_check(opcode_t op, logic [31:0] val, rsp_t want);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CHECK;
    d.op   = op;
    d.val  = val;
    d.want = want;
    return d;
  endfunction

  function automatic dir_row_t row_run(opcode_t op, logic [31:0] val);
    dir_row_t d;
    d = '0;
    d.kind = ROW_RUN;
    d.op   = op;
    d.val  = val;
    return d;
  endfunction

  function automatic dir_row_t row_limit(logic [LIM_W-1:0] lim);
    dir_row_t d;
    d = '0;
    d.kind = ROW_LIMIT;
    d.op   = OP_CLEAR;
    d.lim  = lim;
    return d;
  endfunction

  // Send one request beat. Called at a falling edge; returns at a falling edge
  // with start still high, so a following beat goes out back to back.
  task automatic send_request(opcode_t op, logic [31:0] val, bit typed, rsp_t want);
    rsp_t pred;
    if (burst_left == 0) begin
      // End of a burst: drop start for a random gap, sometimes none at all.
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start          <= 1'b1;
    req.opcode     <= op;
    req.push_value <= val;
    // Hold the beat until an edge with busy low takes it.
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pred = predict_stack(op, val);
    pending_rsp.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Write the limit register once the block has drained. Called at a falling edge.
  task automatic write_limit(logic [LIM_W-1:0] lim);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    model_limit = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker: every done beat must match the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOWN_ERRORS)
          $display("unexpected result beat: status=%0d read=%h count=%0d empty=%b full=%b",
                   rsp.status, rsp.read_value, rsp.item_count, rsp.is_empty, rsp.is_full);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.read_value !== want.read_value ||
            rsp.item_count !== want.item_count || rsp.is_empty !== want.is_empty ||
            rsp.is_full !== want.is_full) begin
          err_cnt++;
          if (err_cnt <= SHOWN_ERRORS) begin
            $display("result mismatch: expected status=%0d read=%h count=%0d empty=%b full=%b",
                     want.status, want.read_value, want.item_count, want.is_empty,
                     want.is_full);
            $display("                   actual status=%0d read=%h count=%0d empty=%b full=%b",
                     rsp.status, rsp.read_value, rsp.item_count, rsp.is_empty, rsp.is_full);
          end
        end
      end
    end
  end

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bounded_lifo_stack_test NOT OK");
      $finish;
    end
  end

  initial begin
    int          ph_lim_lo [NUM_PHASES] = '{256, 4, 0, 511, 1, 2, 0, 2};
    int          ph_lim_hi [NUM_PHASES] = '{256, 4, 0, 511, 1, 16, 511, 2};
    int          ph_items  [NUM_PHASES] = '{300, 60, 60, 80, 60, 80, 80, 80};
    int          ph_push   [NUM_PHASES] = '{92, 40, 50, 60, 50, 55, 55, 50};
    int          ph_clear  [NUM_PHASES] = '{0, 2, 5, 3, 5, 4, 3, 5};
    logic [31:0] extremes  [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF};
    dir_row_t    d;
    opcode_t     op;
    logic [31:0] val;
    int          pick;

    err_cnt     = 0;
    cycles      = 0;
    burst_left  = 0;
    model_count = 0;
    model_limit = LIM_W'(DEPTH);
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;

    // Directed table: empty errors after reset, extreme values, clear, and the
    // limit at one, at zero, above the depth and lowered below the count.
    dir_tab.push_back(row_check(OP_POP,  32'h0, mk_rsp(STAT_EMPTY, 32'h0, 0, 1'b1, 1'b0)));
    dir_tab.push_back(row_check(OP_PEEK, 32'h0, mk_rsp(STAT_EMPTY, 32'h0, 0, 1'b1, 1'b0)));
    dir_tab.push_back(row_check(OP_PUSH, 32'h7FFF_FFFF, mk_rsp(STAT_OK, 32'h0, 1, 1'b0, 1'b0)));
    dir_tab.push_back(row_check(OP_PUSH, 32'h8000_0000, mk_rsp(STAT_OK, 32'h0, 2, 1'b0, 1'b0)));
    dir_tab.push_back(row_check(OP_PEEK, 32'h0,
                                mk_rsp(STAT_OK, 32'h8000_0000, 2, 1'b0, 1'b0)));
    dir_tab.push_back(row_check(OP_POP,  32'h0,
                                mk_rsp(STAT_OK, 32'h8000_0000, 1, 1'b0, 1'b0)));
    dir_tab.push_back(row_check(OP_POP,  32'hFFFF_FFFF,
                                mk_rsp(STAT_OK, 32'h7FFF_FFFF, 0, 1'b1, 1'b0)));
    dir_tab.push_back(row_run(OP_PUSH, 32'hFFFF_FFFF));
    dir_tab.push_back(row_run(OP_PUSH, 32'h0));
    dir_tab.push_back(row_check(OP_CLEAR, 32'hFFFF_FFFF, mk_rsp(STAT_OK, 32'h0, 0, 1'b1, 1'b0)));
    dir_tab.push_back(row_check(OP_CLEAR, 32'h0, mk_rsp(STAT_OK, 32'h0, 0, 1'b1, 1'b0)));
    dir_tab.push_back(row_limit(9'd1));
    dir_tab.push_back(row_check(OP_PUSH, 32'hA5A5_A5A5, mk_rsp(STAT_OK, 32'h0, 1, 1'b0, 1'b1)));
    dir_tab.push_back(row_check(OP_PUSH, 32'h5A5A_5A5A, mk_rsp(STAT_FULL, 32'h0, 1, 1'b0, 1'b1)));
    dir_tab.push_back(row_run(OP_PEEK, 32'h0));
    dir_tab.push_back(row_limit(9'd0));
    dir_tab.push_back(row_check(OP_PUSH, 32'h1, mk_rsp(STAT_FULL, 32'h0, 1, 1'b0, 1'b1)));
    dir_tab.push_back(row_run(OP_POP, 32'h0));
    dir_tab.push_back(row_limit(9'd511));
    dir_tab.push_back(row_run(OP_PUSH, 32'h1234_5678));
    dir_tab.push_back(row_run(OP_PUSH, 32'h0F0F_0F0F));
    dir_tab.push_back(row_limit(9'd1));
    dir_tab.push_back(row_check(OP_PUSH, 32'hCAFE_0001, mk_rsp(STAT_FULL, 32'h0, 2, 1'b0, 1'b1)));
    dir_tab.push_back(row_run(OP_POP, 32'h0));
    dir_tab.push_back(row_run(OP_CLEAR, 32'h0));

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      d = dir_tab[i];
      if (d.kind == ROW_LIMIT) begin
        write_limit(d.lim);
      end else begin
        send_request(d.op, d.val, d.kind == ROW_CHECK, d.want);
      end
    end

    // Random phases. The first fills the stack to the full depth; the next
    // lowers the limit under the count without clearing, then the limit walks
    // through zero, above the depth, one and random values.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(LIM_W'($urandom_range(ph_lim_lo[p], ph_lim_hi[p])));
      for (int n = 0; n < ph_items[p]; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < ph_clear[p]) begin
          op = OP_CLEAR;
        end else if (pick < ph_clear[p] + ph_push[p]) begin
          op = OP_PUSH;
        end else if ($urandom_range(0, 1) == 0) begin
          op = OP_POP;
        end else begin
          op = OP_PEEK;
        end
        val = $urandom();
        if ($urandom_range(0, 15) == 0) val = extremes[$urandom_range(0, 3)];
        send_request(op, val, 1'b0, '0);
      end
    end

    // Drain: drop start, wait for every expected beat, then a short tail.
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("bounded_lifo_stack_test OK");
    end else begin
      $display("bounded_lifo_stack_test NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/blstk_pkg.sv
design/blstk_ctrl.sv
design/blstk_dp.sv
design/bounded_lifo_stack.sv
verif/bounded_lifo_stack_test.sv
